// ===== src/u8u16_pkg.sv =====
// Shared types and constants of the UTF-8/UTF-16 stream decoder.
`default_nettype none

package u8u16_pkg;

    localparam logic [1:0] MODE_AUTO    = 2'd0;
    localparam logic [1:0] MODE_UTF8    = 2'd1;
    localparam logic [1:0] MODE_UTF16LE = 2'd2;
    localparam logic [1:0] MODE_UTF16BE = 2'd3;

    localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

    // Result queue geometry: one item can push up to MAX_RESULTS entries.
    localparam int MAX_RESULTS = 3;
    localparam int RQ_DEPTH    = 4;
    localparam int RQ_PTR_W    = 2;
    localparam int RQ_CNT_W    = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        replaced;
        logic        last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  active_mode;
        logic [20:0] partial_scalar;
        logic [7:0]  lead_byte;
        logic [2:0]  expected_length;
        logic [2:0]  bytes_seen;
        logic [7:0]  odd_byte;
        logic        odd_byte_valid;
        logic [15:0] high_surrogate;
        logic        high_surrogate_valid;
    } dec_state_t;

    // Up to three code units produced by one item, in order.
    typedef struct packed {
        logic [1:0]       count;
        logic [2:0][15:0] code_units;
        logic [2:0]       repl;
    } dec_res_t;

endpackage

`default_nettype wire

// ===== src/u8u16_dec.sv =====
// Decoder state and per-item next-state logic: mark detection, UTF-8 and UTF-16 decoding.
`default_nettype none

module u8u16_dec (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_wdata,
    input  wire logic                accept,
    input  wire u8u16_pkg::in_item_t in_item,
    output u8u16_pkg::dec_res_t      res
);
    import u8u16_pkg::*;

    typedef struct packed {
        dec_state_t st;
        dec_res_t   res;
    } step_t;

    logic [1:0] mode_reg;
    dec_state_t st_reg, st_next;
    logic       mark_checked_reg, mark_checked_next;
    logic [1:0] held_cnt_reg, held_cnt_next;
    logic [7:0] held0_reg, held0_next;
    logic [7:0] held1_reg, held1_next;

    function automatic dec_res_t res_push(dec_res_t r, logic [15:0] u, logic rp);
        dec_res_t o;
        o = r;
        if (r.count != 2'd3) begin
            o.code_units[r.count] = u;
            o.repl[r.count]       = rp;
            o.count               = r.count + 2'd1;
        end
        return o;
    endfunction

    function automatic dec_state_t u8_clear(dec_state_t s);
        dec_state_t o;
        o = s;
        o.partial_scalar  = '0;
        o.lead_byte       = '0;
        o.expected_length = '0;
        o.bytes_seen      = '0;
        return o;
    endfunction

    function automatic dec_state_t restart_state(logic [1:0] mode);
        dec_state_t o;
        o = '0;
        o.active_mode = mode;
        return o;
    endfunction

    function automatic step_t u8_start(step_t x, logic [7:0] b);
        step_t      o;
        logic [2:0] len;
        o   = x;
        len = 3'd0;
        if (!b[7]) begin
            o.res = res_push(x.res, {8'h00, b}, 1'b0);
        end else begin
            if (b >= 8'hC2 && b <= 8'hDF) begin
                len = 3'd2;
            end else if (b >= 8'hE0 && b <= 8'hEF) begin
                len = 3'd3;
            end else if (b >= 8'hF0 && b <= 8'hF4) begin
                len = 3'd4;
            end
            if (len == 3'd0) begin
                o.res = res_push(x.res, REPL_UNIT, 1'b1);
            end else begin
                o.st.lead_byte       = b;
                o.st.expected_length = len;
                o.st.bytes_seen      = 3'd1;
                if (len == 3'd2) begin
                    o.st.partial_scalar = {16'h0000, b[4:0]};
                end else if (len == 3'd3) begin
                    o.st.partial_scalar = {17'h00000, b[3:0]};
                end else begin
                    o.st.partial_scalar = {18'h00000, b[2:0]};
                end
            end
        end
        return o;
    endfunction

    function automatic step_t u8_feed(step_t x, logic [7:0] b);
        step_t       o;
        logic        ok;
        logic [20:0] ps;
        logic [20:0] s;
        logic [2:0]  seen_n;
        o      = x;
        ok     = 1'b0;
        ps     = '0;
        s      = '0;
        seen_n = '0;
        if (x.st.expected_length == 3'd0) begin
            o = u8_start(x, b);
        end else begin
            ok = (b[7:6] == 2'b10);
            // The second byte narrows the range to exclude overlongs, surrogates
            // and scalars beyond the top of the code space.
            if (ok && x.st.bytes_seen == 3'd1) begin
                if ((x.st.lead_byte == 8'hE0 && b < 8'hA0) ||
                    (x.st.lead_byte == 8'hED && b > 8'h9F) ||
                    (x.st.lead_byte == 8'hF0 && b < 8'h90) ||
                    (x.st.lead_byte == 8'hF4 && b > 8'h8F)) begin
                    ok = 1'b0;
                end
            end
            if (!ok) begin
                o.res = res_push(x.res, REPL_UNIT, 1'b1);
                o.st  = u8_clear(x.st);
                o     = u8_start(o, b);
            end else begin
                ps     = {x.st.partial_scalar[14:0], b[5:0]};
                seen_n = x.st.bytes_seen + 3'd1;
                o.st.partial_scalar = ps;
                o.st.bytes_seen     = seen_n;
                if (seen_n >= x.st.expected_length) begin
                    if (ps > 21'h00FFFF) begin
                        s     = ps - 21'h010000;
                        o.res = res_push(o.res, HI_SURR_BASE + {6'h00, s[19:10]}, 1'b0);
                        o.res = res_push(o.res, LO_SURR_BASE + {6'h00, s[9:0]}, 1'b0);
                    end else begin
                        o.res = res_push(o.res, ps[15:0], 1'b0);
                    end
                    o.st = u8_clear(o.st);
                end
            end
        end
        return o;
    endfunction

    function automatic step_t u16_unit(step_t x, logic [15:0] u);
        step_t o;
        logic  is_high;
        logic  is_low;
        logic  paired;
        o       = x;
        is_high = (u[15:10] == 6'b110110);
        is_low  = (u[15:10] == 6'b110111);
        paired  = 1'b0;
        if (x.st.high_surrogate_valid) begin
            o.st.high_surrogate_valid = 1'b0;
            if (is_low) begin
                o.res  = res_push(o.res, x.st.high_surrogate, 1'b0);
                o.res  = res_push(o.res, u, 1'b0);
                paired = 1'b1;
            end else begin
                o.res = res_push(o.res, REPL_UNIT, 1'b1);
            end
        end
        if (!paired) begin
            if (is_high) begin
                o.st.high_surrogate       = u;
                o.st.high_surrogate_valid = 1'b1;
            end else if (is_low) begin
                o.res = res_push(o.res, REPL_UNIT, 1'b1);
            end else begin
                o.res = res_push(o.res, u, 1'b0);
            end
        end
        return o;
    endfunction

    function automatic step_t u16_feed(step_t x, logic [7:0] b);
        step_t       o;
        logic [15:0] u;
        o = x;
        u = '0;
        if (!x.st.odd_byte_valid) begin
            o.st.odd_byte       = b;
            o.st.odd_byte_valid = 1'b1;
        end else begin
            o.st.odd_byte_valid = 1'b0;
            if (x.st.active_mode == MODE_UTF16LE) begin
                u = {b, x.st.odd_byte};
            end else begin
                u = {x.st.odd_byte, b};
            end
            o = u16_unit(o, u);
        end
        return o;
    endfunction

    function automatic step_t feed(step_t x, logic [7:0] b);
        step_t o;
        if (x.st.active_mode[1]) begin
            o = u16_feed(x, b);
        end else begin
            o = u8_feed(x, b);
        end
        return o;
    endfunction

    function automatic step_t flush(step_t x);
        step_t o;
        o = x;
        if (x.st.active_mode[1]) begin
            if (x.st.high_surrogate_valid) begin
                o.res = res_push(o.res, REPL_UNIT, 1'b1);
            end
            if (x.st.odd_byte_valid) begin
                o.res = res_push(o.res, REPL_UNIT, 1'b1);
            end
        end else if (x.st.expected_length != 3'd0) begin
            o.res = res_push(o.res, REPL_UNIT, 1'b1);
        end
        o.st                      = u8_clear(o.st);
        o.st.high_surrogate_valid = 1'b0;
        o.st.high_surrogate       = '0;
        o.st.odd_byte_valid       = 1'b0;
        o.st.odd_byte             = '0;
        return o;
    endfunction

    function automatic logic [7:0] mark_byte(logic [1:0] m, logic [1:0] i);
        logic [7:0] v;
        case ({m, i})
            4'b00_00: v = 8'hEF;
            4'b00_01: v = 8'hBB;
            4'b00_10: v = 8'hBF;
            4'b01_00: v = 8'hFF;
            4'b01_01: v = 8'hFE;
            4'b10_00: v = 8'hFE;
            4'b10_01: v = 8'hFF;
            default:  v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] mark_len(logic [1:0] m);
        return (m == 2'd0) ? 2'd3 : 2'd2;
    endfunction

    function automatic logic mark_prefix(logic [1:0] m, logic [2:0][7:0] mb, logic [1:0] n);
        logic hit;
        hit = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < n && mb[i] != mark_byte(m, 2'(i))) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    always_comb begin
        step_t           x;
        logic [2:0][7:0] mb;
        logic [1:0]      n;
        logic            absorbed;
        logic [1:0]      m;
        x                 = '0;
        x.st              = st_reg;
        mb                = {3{in_item.in_byte}};
        n                 = held_cnt_reg + 2'd1;
        absorbed          = 1'b0;
        m                 = '0;
        mark_checked_next = mark_checked_reg;
        held_cnt_next     = held_cnt_reg;
        held0_next        = held0_reg;
        held1_next        = held1_reg;

        if (!mark_checked_reg) begin
            if (held_cnt_reg != 2'd0) begin
                mb[0] = held0_reg;
            end
            if (held_cnt_reg == 2'd2) begin
                mb[1] = held1_reg;
            end
            for (int k = 0; k < 3; k++) begin
                m = 2'(k);
                if (!absorbed && (mode_reg == MODE_AUTO || mode_reg == 2'(k + 1)) &&
                    n <= mark_len(m) && mark_prefix(m, mb, n)) begin
                    if (n < mark_len(m) && !in_item.end_of_stream) begin
                        // Still a proper prefix of a mark: hold the byte.
                        if (n == 2'd1) begin
                            held0_next = in_item.in_byte;
                        end else begin
                            held1_next = in_item.in_byte;
                        end
                        held_cnt_next = n;
                        absorbed      = 1'b1;
                    end else if (n == mark_len(m)) begin
                        x.st.active_mode  = 2'(k + 1);
                        mark_checked_next = 1'b1;
                        held_cnt_next     = 2'd0;
                        absorbed          = 1'b1;
                    end
                end
            end
            if (!absorbed) begin
                mark_checked_next = 1'b1;
                held_cnt_next     = 2'd0;
            end
        end

        // Mark checked: the byte is fed. No mark matched: held bytes are replayed ahead of it.
        if (mark_checked_reg || !absorbed) begin
            x = feed(x, mark_checked_reg ? in_item.in_byte : mb[0]);
            if (!mark_checked_reg && n >= 2'd2) begin
                x = feed(x, mb[1]);
            end
            if (!mark_checked_reg && n == 2'd3) begin
                x = feed(x, mb[2]);
            end
        end
        if (in_item.end_of_stream) begin
            x = flush(x);
        end
        st_next = x.st;
        res     = x.res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_AUTO;
            st_reg           <= restart_state(MODE_AUTO);
            mark_checked_reg <= 1'b0;
            held_cnt_reg     <= 2'd0;
        end else if (cfg_we) begin
            mode_reg         <= cfg_wdata;
            st_reg           <= restart_state(cfg_wdata);
            mark_checked_reg <= 1'b0;
            held_cnt_reg     <= 2'd0;
        end else if (accept) begin
            st_reg           <= st_next;
            mark_checked_reg <= mark_checked_next;
            held_cnt_reg     <= held_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

    a_held_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_cnt_reg != 2'd3)
        else $error("held mark byte count out of range");

    a_no_hold_after_check: assert property (@(posedge aclk) disable iff (!aresetn)
        mark_checked_reg |-> held_cnt_reg == 2'd0)
        else $error("mark bytes held after the mark check finished");

    a_seq_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.expected_length != 3'd0 |->
            (st_reg.bytes_seen >= 3'd1 && st_reg.bytes_seen < st_reg.expected_length))
        else $error("UTF-8 sequence counter inconsistent with its length");

endmodule

`default_nettype wire

// ===== src/u8u16_rq.sv =====
// Result queue: up to three code units in per item, one out per cycle while m_ready.
`default_nettype none

module u8u16_rq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push_en,
    input  wire u8u16_pkg::dec_res_t push_res,
    output logic                     push_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output u8u16_pkg::out_item_t     m_data
);
    import u8u16_pkg::*;

    localparam logic [RQ_CNT_W-1:0] ROOM_LIMIT = RQ_CNT_W'(RQ_DEPTH - MAX_RESULTS);

    out_item_t             mem_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [RQ_CNT_W-1:0]   count_reg, count_next;
    logic [1:0]            n_push;
    logic                  pop;

    assign n_push     = push_en ? push_res.count : 2'd0;
    assign pop        = m_valid && m_ready;
    assign push_ready = (count_reg <= ROOM_LIMIT);
    assign m_valid    = (count_reg != '0);
    assign m_data     = mem_reg[rd_ptr_reg];
    assign count_next = count_reg + RQ_CNT_W'(n_push) - RQ_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + RQ_PTR_W'(n_push);
            rd_ptr_reg <= rd_ptr_reg + RQ_PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (2'(k) < n_push) begin
                mem_reg[wr_ptr_reg + RQ_PTR_W'(k)] <= '{
                    code_unit:   push_res.code_units[k],
                    replaced:    push_res.repl[k],
                    last_of_run: (2'(k) == n_push - 2'd1)
                };
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= RQ_CNT_W'(RQ_DEPTH))
        else $error("result queue overfilled");

    a_pop_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && n_push == 2'd0) |=> count_reg == RQ_CNT_W'($past(count_reg) - 3'd1))
        else $error("result queue count did not drop after a pop");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_en |-> push_ready)
        else $error("item taken while the result queue lacked room");

endmodule

`default_nettype wire

// ===== src/utf8_utf16_stream_decoder.sv =====
// An accepted item's code units are queued in the result queue behind earlier ones.
// Throughput: one item per cycle while items give at most one result each and m_ready
// is high; the output channel moves one code unit per cycle while m_ready is high, and
// s_ready drops while the four-entry result queue lacks room for three more entries.
// Reset: synchronous, active-low aresetn sets the mode to auto and restarts the stream;
// a write to the mode register restarts the decoder state but not the result queue.
`default_nettype none

module utf8_utf16_stream_decoder (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire u8u16_pkg::in_item_t  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output u8u16_pkg::out_item_t      m_data
);
    import u8u16_pkg::*;

    logic     accept;
    dec_res_t res;

    assign accept = s_valid && s_ready;

    u8u16_dec u_dec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .in_item   (s_data),
        .res       (res)
    );

    u8u16_rq u_rq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_en    (accept),
        .push_res   (res),
        .push_ready (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire
